[hdl/lcdw_pkg.sv]
// Shared types and constants for the 4-bit character LCD writer.
package lcdw_pkg;

  localparam logic [1:0] OP_CMD    = 2'd0;
  localparam logic [1:0] OP_DATA   = 2'd1;
  localparam logic [1:0] OP_CURSOR = 2'd2;
  localparam logic [1:0] OP_NIBBLE = 2'd3;

  localparam logic [7:0] SET_DDRAM_CMD = 8'h80;

  localparam int unsigned STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_RS      = 4'd0;
  localparam logic [STEP_W-1:0] STEP_HI      = 4'd1;
  localparam logic [STEP_W-1:0] STEP_EN_LO_A = 4'd2;
  localparam logic [STEP_W-1:0] STEP_EN_HI_A = 4'd3;
  localparam logic [STEP_W-1:0] STEP_EN_LO_B = 4'd4;
  localparam logic [STEP_W-1:0] STEP_LO      = 4'd5;
  localparam logic [STEP_W-1:0] STEP_EN_LO_C = 4'd6;
  localparam logic [STEP_W-1:0] STEP_EN_HI_B = 4'd7;
  localparam logic [STEP_W-1:0] STEP_EN_LO_D = 4'd8;

  typedef struct packed {
    logic       nibble;
    logic       rs;
    logic [7:0] byte_val;
  } job_t;

  function automatic logic [6:0] row_base(input logic [1:0] row);
    logic [6:0] base;
    case (row)
      2'd0:    base = 7'h00;
      2'd1:    base = 7'h40;
      2'd2:    base = 7'h14;
      2'd3:    base = 7'h54;
      default: base = 7'h00;
    endcase
    return base;
  endfunction

endpackage

[hdl/char_lcd_4bit_writer_unit.sv]
// Top level of the 4-bit character LCD writer.
//
//   channel  | handshake            | payload
//   ---------+----------------------+------------------------------------
//   request  | in_valid / in_stall  | opcode, value, row, column
//   pin step | out_valid / out_stall| rs_pin, en_pin, data_pins, last
//
// A byte request yields nine pin steps and a nibble request five, one per
// cycle from the step sequencer while the output is not stalled.
// The input register holds the next request while the current one steps.
// Reset (rst, synchronous) empties both stages and drives all pins low.
// A stalled step holds the result register and pauses the sequence.
module char_lcd_4bit_writer_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] opcode,
  input  logic [7:0] value,
  input  logic [1:0] row,
  input  logic [5:0] column,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       rs_pin,
  output logic       en_pin,
  output logic [3:0] data_pins,
  output logic       last
);

  logic           job_valid;
  logic           job_take;
  lcdw_pkg::job_t job;

  lcdw_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .opcode    (opcode),
    .value     (value),
    .row       (row),
    .column    (column),
    .job_valid (job_valid),
    .job       (job),
    .job_take  (job_take)
  );

  lcdw_stepper u_stepper (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job       (job),
    .job_take  (job_take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .rs_pin    (rs_pin),
    .en_pin    (en_pin),
    .data_pins (data_pins),
    .last      (last)
  );

endmodule

[hdl/lcdw_decode.sv]
// Input register: turns a request into the byte, RS level and kind to send.
module lcdw_decode (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        opcode,
  input  logic [7:0]        value,
  input  logic [1:0]        row,
  input  logic [5:0]        column,
  output logic              job_valid,
  output lcdw_pkg::job_t    job,
  input  logic              job_take
);

  lcdw_pkg::job_t job_next;
  logic [6:0]     addr;

  assign in_stall = job_valid && !job_take;

  // address wraps to 7 bits before the set-DDRAM bit goes in
  assign addr = lcdw_pkg::row_base(row) + {1'b0, column};

  always_comb begin
    job_next.nibble   = (opcode == lcdw_pkg::OP_NIBBLE);
    job_next.rs       = (opcode == lcdw_pkg::OP_DATA);
    job_next.byte_val = value;
    case (opcode)
      lcdw_pkg::OP_CURSOR: job_next.byte_val = lcdw_pkg::SET_DDRAM_CMD | {1'b0, addr};
      lcdw_pkg::OP_NIBBLE: job_next.byte_val = {4'h0, value[3:0]};
      default:             job_next.byte_val = value;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (!in_stall) begin
      job_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      job <= job_next;
    end
  end

endmodule

[hdl/lcdw_stepper.sv]
// Step sequencer: walks one request through its pin steps into the result register.
module lcdw_stepper (
  input  logic              clk,
  input  logic              rst,
  input  logic              job_valid,
  input  lcdw_pkg::job_t    job,
  output logic              job_take,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              rs_pin,
  output logic              en_pin,
  output logic [3:0]        data_pins,
  output logic              last
);

  lcdw_pkg::job_t               cur;
  logic                         busy;
  logic [lcdw_pkg::STEP_W-1:0]  step;
  logic                         gen;
  logic                         final_step;
  logic                         rs_next;
  logic                         en_next;
  logic [3:0]                   data_next;
  logic [3:0]                   hi_nib;

  assign gen        = busy && (!out_valid || !out_stall);
  assign final_step = cur.nibble ? (step == lcdw_pkg::STEP_EN_LO_B)
                                 : (step == lcdw_pkg::STEP_EN_LO_D);
  assign job_take   = !busy || (gen && final_step);

  // a nibble request sends its nibble where a byte sends the high half
  assign hi_nib = cur.nibble ? cur.byte_val[3:0] : cur.byte_val[7:4];

  always_comb begin
    rs_next   = rs_pin;
    en_next   = en_pin;
    data_next = data_pins;
    case (step)
      lcdw_pkg::STEP_RS:      rs_next   = cur.rs;
      lcdw_pkg::STEP_HI:      data_next = hi_nib;
      lcdw_pkg::STEP_LO:      data_next = cur.byte_val[3:0];
      lcdw_pkg::STEP_EN_HI_A,
      lcdw_pkg::STEP_EN_HI_B: en_next   = 1'b1;
      default:                en_next   = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      step      <= lcdw_pkg::STEP_RS;
      out_valid <= 1'b0;
      rs_pin    <= 1'b0;
      en_pin    <= 1'b0;
      data_pins <= 4'h0;
      last      <= 1'b0;
    end else begin
      if (gen) begin
        out_valid <= 1'b1;
        rs_pin    <= rs_next;
        en_pin    <= en_next;
        data_pins <= data_next;
        last      <= final_step;
        step      <= final_step ? lcdw_pkg::STEP_RS : step + 4'd1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (job_take) begin
        busy <= job_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_take && job_valid) begin
      cur <= job;
    end
  end

endmodule
